// ----- hdl/btedit_pkg.sv -----
// btedit_pkg: shared constants, op codes and controller/datapath bundles
// for the block-transposition edit distance engine. No dependencies.
package btedit_pkg;

  localparam int MAX_LEN   = 64;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int SIDE      = MAX_LEN + 1;
  localparam int MAT_DEPTH = SIDE * SIDE;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int BL_W      = 6;
  localparam int MD_W      = 8;

  localparam logic [1:0] CMD_APPEND_A = 2'd0;
  localparam logic [1:0] CMD_APPEND_B = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;

  typedef logic [4:0] op_t;
  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD_A    = 5'd1;
  localparam op_t OP_LOAD_B    = 5'd2;
  localparam op_t OP_START     = 5'd3;
  localparam op_t OP_PRE_RD    = 5'd4;
  localparam op_t OP_INC_I     = 5'd5;
  localparam op_t OP_SUF_RD    = 5'd6;
  localparam op_t OP_INC_J     = 5'd7;
  localparam op_t OP_TRIM      = 5'd8;
  localparam op_t OP_ROW_RD    = 5'd9;
  localparam op_t OP_LATCH_A   = 5'd10;
  localparam op_t OP_CELL_RD   = 5'd11;
  localparam op_t OP_CELL_SUB  = 5'd12;
  localparam op_t OP_LEN_DEC   = 5'd13;
  localparam op_t OP_BLK_START = 5'd14;
  localparam op_t OP_BLK_RD1   = 5'd15;
  localparam op_t OP_BLK_RD2   = 5'd16;
  localparam op_t OP_K_INC     = 5'd17;
  localparam op_t OP_BLK_HIT   = 5'd18;
  localparam op_t OP_NO_BLK    = 5'd19;
  localparam op_t OP_CELL_WR   = 5'd20;
  localparam op_t OP_NEXT_ROW  = 5'd21;
  localparam op_t OP_RES_BEST  = 5'd22;
  localparam op_t OP_RES_LEFT  = 5'd23;
  localparam op_t OP_FINISH    = 5'd24;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic pre_ok;
    logic suf_ok;
    logic bytes_eq;
    logic trim_zero;
    logic trim_one;
    logic len_zero;
    logic blk_fits;
    logic k_last;
    logic t_last;
    logic s_last;
    logic abort;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/btedit_ctrl.sv -----
// btedit_ctrl: sequencer for loading, trimming and the cost-matrix walk.
// Depends on btedit_pkg; drives btedit_dp through dp_cmd_t.
module btedit_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_cmd,
  output logic                   in_ready,
  input  btedit_pkg::dp_status_t sts,
  output btedit_pkg::dp_cmd_t    cmd
);
  import btedit_pkg::*;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_PRE_RD    = 5'd1;
  localparam logic [4:0] ST_PRE_CMP   = 5'd2;
  localparam logic [4:0] ST_SUF_RD    = 5'd3;
  localparam logic [4:0] ST_SUF_CMP   = 5'd4;
  localparam logic [4:0] ST_TRIM      = 5'd5;
  localparam logic [4:0] ST_ROW_RD    = 5'd6;
  localparam logic [4:0] ST_ROW_LATCH = 5'd7;
  localparam logic [4:0] ST_CELL_RD   = 5'd8;
  localparam logic [4:0] ST_CELL_SUB  = 5'd9;
  localparam logic [4:0] ST_BLK_TEST  = 5'd10;
  localparam logic [4:0] ST_BLK_RD1   = 5'd11;
  localparam logic [4:0] ST_BLK_C1    = 5'd12;
  localparam logic [4:0] ST_BLK_C2    = 5'd13;
  localparam logic [4:0] ST_CELL_WR   = 5'd14;
  localparam logic [4:0] ST_ROW_END   = 5'd15;
  localparam logic [4:0] ST_DONE      = 5'd16;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_APPEND_A: cmd.op = OP_LOAD_A;
            CMD_APPEND_B: cmd.op = OP_LOAD_B;
            CMD_FINISH: begin
              cmd.op     = OP_START;
              state_next = ST_PRE_RD;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_PRE_RD: begin
        if (sts.pre_ok) begin
          cmd.op     = OP_PRE_RD;
          state_next = ST_PRE_CMP;
        end else begin
          state_next = ST_SUF_RD;
        end
      end
      ST_PRE_CMP: begin
        if (sts.bytes_eq) begin
          cmd.op     = OP_INC_I;
          state_next = ST_PRE_RD;
        end else begin
          state_next = ST_SUF_RD;
        end
      end
      ST_SUF_RD: begin
        if (sts.suf_ok) begin
          cmd.op     = OP_SUF_RD;
          state_next = ST_SUF_CMP;
        end else begin
          state_next = ST_TRIM;
        end
      end
      ST_SUF_CMP: begin
        if (sts.bytes_eq) begin
          cmd.op     = OP_INC_J;
          state_next = ST_SUF_RD;
        end else begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        cmd.op     = OP_TRIM;
        state_next = (sts.trim_zero || sts.trim_one) ? ST_DONE : ST_ROW_RD;
      end
      ST_ROW_RD: begin
        cmd.op     = OP_ROW_RD;
        state_next = ST_ROW_LATCH;
      end
      ST_ROW_LATCH: begin
        cmd.op     = OP_LATCH_A;
        state_next = ST_CELL_RD;
      end
      ST_CELL_RD: begin
        cmd.op     = OP_CELL_RD;
        state_next = ST_CELL_SUB;
      end
      ST_CELL_SUB: begin
        cmd.op     = OP_CELL_SUB;
        state_next = ST_BLK_TEST;
      end
      ST_BLK_TEST: begin
        if (sts.len_zero) begin
          cmd.op     = OP_NO_BLK;
          state_next = ST_CELL_WR;
        end else if (sts.blk_fits) begin
          cmd.op     = OP_BLK_START;
          state_next = ST_BLK_RD1;
        end else begin
          cmd.op = OP_LEN_DEC;
        end
      end
      ST_BLK_RD1: begin
        cmd.op     = OP_BLK_RD1;
        state_next = ST_BLK_C1;
      end
      ST_BLK_C1: begin
        if (sts.bytes_eq) begin
          cmd.op     = OP_BLK_RD2;
          state_next = ST_BLK_C2;
        end else begin
          cmd.op     = OP_LEN_DEC;
          state_next = ST_BLK_TEST;
        end
      end
      ST_BLK_C2: begin
        if (!sts.bytes_eq) begin
          cmd.op     = OP_LEN_DEC;
          state_next = ST_BLK_TEST;
        end else if (sts.k_last) begin
          cmd.op     = OP_BLK_HIT;
          state_next = ST_CELL_WR;
        end else begin
          cmd.op     = OP_K_INC;
          state_next = ST_BLK_RD1;
        end
      end
      ST_CELL_WR: begin
        cmd.op     = OP_CELL_WR;
        state_next = sts.t_last ? ST_ROW_END : ST_CELL_RD;
      end
      ST_ROW_END: begin
        if (sts.abort) begin
          cmd.op     = OP_RES_BEST;
          state_next = ST_DONE;
        end else if (sts.s_last) begin
          cmd.op     = OP_RES_LEFT;
          state_next = ST_DONE;
        end else begin
          cmd.op     = OP_NEXT_ROW;
          state_next = ST_ROW_RD;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result only leaves through the done state
  a_finish_from_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |-> (state == ST_DONE && sts.out_free))
    else $error("finish issued outside done");

  // the walk starts only from an accepted finish word
  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && state_next == ST_PRE_RD) |-> (in_valid && in_cmd == CMD_FINISH))
    else $error("compute started without finish");

  // a block hit needs a nonzero length
  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_BLK_HIT) |-> !sts.len_zero)
    else $error("block hit at zero length");

endmodule

// ----- hdl/btedit_dp.sv -----
// btedit_dp: string stores, cost-matrix memory, trim counters, cell
// arithmetic and the output register. Depends on btedit_pkg.
module btedit_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  btedit_pkg::dp_cmd_t         cmd,
  output btedit_pkg::dp_status_t      sts,
  input  logic [7:0]                  in_byte,
  input  logic [btedit_pkg::BL_W-1:0] swap_limit,
  input  logic [btedit_pkg::MD_W-1:0] abort_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_distance,
  output logic                        out_too_long
);
  import btedit_pkg::*;

  logic [7:0]       mem_a [MAX_LEN];
  logic [7:0]       mem_b [MAX_LEN];
  logic [LEN_W-1:0] mem_m [MAT_DEPTH];

  logic [LEN_W-1:0] len1, len2;
  logic             ovf;
  logic [7:0]       rd_a, rd_b;
  logic [LEN_W-1:0] mem_q, mr, mc;
  logic [LEN_W-1:0] i, j, n1, n2, s, t;
  logic [BL_W-1:0]  len, k, base;
  logic [LEN_W-1:0] left, up, diag;
  logic             sub, blk;
  logic [7:0]       a_cur;
  logic [MD_W-1:0]  best;
  logic [7:0]       result;

  // read port selection
  logic             ra_en, rb_en, rm_en;
  logic [7:0]       ra_full, rb_full;
  logic [LEN_W-1:0] rm_r, rm_c;
  logic [7:0]       ij, twol;
  logic [LEN_W-1:0] n1c, n2c, mq;
  logic [BL_W-1:0]  h1, h2, base_c;
  logic [7:0]       l1, u1, c3, m1, vfull;
  logic [LEN_W-1:0] v;

  assign ij   = {1'b0, i} + {1'b0, j};
  assign twol = {1'b0, len, 1'b0};

  always_comb begin
    ra_en   = 1'b0;
    rb_en   = 1'b0;
    rm_en   = 1'b0;
    ra_full = '0;
    rb_full = '0;
    rm_r    = '0;
    rm_c    = '0;
    case (cmd.op)
      OP_PRE_RD: begin
        ra_en = 1'b1; rb_en = 1'b1;
        ra_full = {1'b0, i};
        rb_full = {1'b0, i};
      end
      OP_SUF_RD: begin
        ra_en = 1'b1; rb_en = 1'b1;
        ra_full = {1'b0, len1} - 8'd1 - {1'b0, j};
        rb_full = {1'b0, len2} - 8'd1 - {1'b0, j};
      end
      OP_ROW_RD: begin
        ra_en = 1'b1;
        ra_full = {1'b0, i} + {1'b0, s} - 8'd1;
      end
      OP_CELL_RD: begin
        rb_en = 1'b1; rm_en = 1'b1;
        rb_full = {1'b0, i} + {1'b0, t} - 8'd1;
        rm_r = s - 1'b1;
        rm_c = t;
      end
      OP_BLK_RD1: begin
        ra_en = 1'b1; rb_en = 1'b1;
        ra_full = {1'b0, i} + {1'b0, s} - twol + {2'b0, k};
        rb_full = {1'b0, i} + {1'b0, t} - {2'b0, len} + {2'b0, k};
      end
      OP_BLK_RD2: begin
        ra_en = 1'b1; rb_en = 1'b1;
        ra_full = {1'b0, i} + {1'b0, s} - {2'b0, len} + {2'b0, k};
        rb_full = {1'b0, i} + {1'b0, t} - twol + {2'b0, k};
      end
      OP_BLK_HIT: begin
        rm_en = 1'b1;
        rm_r = s - twol[LEN_W-1:0];
        rm_c = t - twol[LEN_W-1:0];
      end
      default: ra_en = 1'b0;
    endcase
  end

  // string stores: append port and one read port each
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_A && len1 < LEN_W'(MAX_LEN)) begin
      mem_a[len1[IDX_W-1:0]] <= in_byte;
    end
    if (ra_en) begin
      rd_a <= mem_a[ra_full[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_B && len2 < LEN_W'(MAX_LEN)) begin
      mem_b[len2[IDX_W-1:0]] <= in_byte;
    end
    if (rb_en) begin
      rd_b <= mem_b[rb_full[IDX_W-1:0]];
    end
  end

  // cost matrix: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CELL_WR) begin
      mem_m[MAT_AW'(s * SIDE) + MAT_AW'(t)] <= v;
    end
    if (rm_en) begin
      mem_q <= mem_m[MAT_AW'(rm_r * SIDE) + MAT_AW'(rm_c)];
      mr    <= rm_r;
      mc    <= rm_c;
    end
  end

  // row 0 and column 0 are implicit
  assign mq = (mr == '0) ? mc : ((mc == '0) ? mr : mem_q);

  assign n1c    = len1 - i - j;
  assign n2c    = len2 - i - j;
  assign h1     = n1c[LEN_W-1:1];
  assign h2     = n2c[LEN_W-1:1];
  assign base_c = (swap_limit < ((h1 < h2) ? h1 : h2)) ? swap_limit : ((h1 < h2) ? h1 : h2);

  assign l1    = {1'b0, left} + 8'd1;
  assign u1    = {1'b0, up} + 8'd1;
  assign c3    = blk ? ({1'b0, mq} + {7'b0, sub} + {2'b0, len} - 8'd1)
                     : ({1'b0, diag} + {7'b0, sub});
  assign m1    = (l1 < u1) ? l1 : u1;
  assign vfull = (m1 < c3) ? m1 : c3;
  assign v     = vfull[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      len1      <= '0;
      len2      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD_A: begin
          if (len1 < LEN_W'(MAX_LEN)) len1 <= len1 + 1'b1;
          else ovf <= 1'b1;
        end
        OP_LOAD_B: begin
          if (len2 < LEN_W'(MAX_LEN)) len2 <= len2 + 1'b1;
          else ovf <= 1'b1;
        end
        OP_FINISH: begin
          out_valid    <= 1'b1;
          out_distance <= result;
          out_too_long <= ovf;
          len1         <= '0;
          len2         <= '0;
          ovf          <= 1'b0;
        end
        default: ovf <= ovf;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        i <= '0;
        j <= '0;
      end
      OP_INC_I: i <= i + 1'b1;
      OP_INC_J: j <= j + 1'b1;
      OP_TRIM: begin
        n1   <= n1c;
        n2   <= n2c;
        base <= base_c;
        best <= abort_level;
        s    <= LEN_W'(1);
        if (n1c == '0 || n2c == '0) begin
          result <= {1'b0, (n1c > n2c) ? n1c : n2c};
        end else begin
          result <= 8'd1;
        end
      end
      OP_ROW_RD: begin
        t    <= LEN_W'(1);
        left <= s;
        diag <= s - 1'b1;
      end
      OP_LATCH_A:   a_cur <= rd_a;
      OP_CELL_RD:   len <= base;
      OP_CELL_SUB: begin
        up  <= mq;
        sub <= (a_cur != rd_b);
      end
      OP_LEN_DEC:   len <= len - 1'b1;
      OP_BLK_START: k <= '0;
      OP_K_INC:     k <= k + 1'b1;
      OP_BLK_HIT:   blk <= 1'b1;
      OP_NO_BLK:    blk <= 1'b0;
      OP_CELL_WR: begin
        left <= v;
        diag <= up;
        if ({1'b0, v} < best) best <= {1'b0, v};
        if (t != n2) t <= t + 1'b1;
      end
      OP_NEXT_ROW: s <= s + 1'b1;
      OP_RES_BEST: result <= best;
      OP_RES_LEFT: result <= {1'b0, left};
      default: k <= k;
    endcase
  end

  always_comb begin
    sts.pre_ok    = (i < len1) && (i < len2);
    sts.suf_ok    = (ij < {1'b0, len1}) && (ij < {1'b0, len2});
    sts.bytes_eq  = (rd_a == rd_b);
    sts.trim_zero = (n1c == '0) || (n2c == '0);
    sts.trim_one  = (n1c == LEN_W'(1)) && (n2c == LEN_W'(1));
    sts.len_zero  = (len == '0);
    sts.blk_fits  = ({1'b0, s} >= twol) && ({1'b0, t} >= twol);
    sts.k_last    = (k == len - 1'b1);
    sts.t_last    = (t == n2);
    sts.s_last    = (s == n1);
    sts.abort     = (best >= abort_level);
    sts.out_free  = !out_valid || out_ready;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (len1 <= LEN_W'(MAX_LEN)) && (len2 <= LEN_W'(MAX_LEN)))
    else $error("string length beyond store");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |=> (out_valid && len1 == '0 && len2 == '0 && !ovf))
    else $error("finish did not publish and clear");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_distance)
                                   && $stable(out_too_long)))
    else $error("pending result lost");

  a_cell_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CELL_WR) |-> (vfull <= 8'(MAX_LEN)))
    else $error("cell value out of range");

endmodule

// ----- hdl/block_transposition_edit_distance.sv -----
// block_transposition_edit_distance: top level, configuration registers
// and APB port. Depends on btedit_pkg, btedit_ctrl and btedit_dp.
//
// Usage:
//   Input stream (s_*): one word per byte. s_tuser selects the action:
//   append s_tdata to the first string, append to the second, or finish.
//   Appends beyond 64 bytes are dropped and reported as too_long.
//   Finish computes the modified Damerau-Levenshtein distance with block
//   swaps up to the swap limit and an early abort against the abort level,
//   then emits one word on m_* and clears both strings.
//   Output stream (m_*): m_tdata is the distance, m_tuser the too_long flag.
// Operation:
//   A finish trims the common prefix and suffix byte by byte, then walks
//   the trimmed matrix row by row. Per cell it tries block lengths from
//   B = min(swap limit, n1/2, n2/2) down, comparing two byte pairs per
//   position one after the other (the single read port of each string
//   store sets this), for trimmed lengths n1,n2. Input is not taken
//   while a finish is being computed.
// Reset: synchronous, clears lengths, flags and the output valid flag;
//   the swap limit returns to 2 and the abort level to 255.
// Stall: a result waits in the output register; appends keep being taken,
//   and a following finish holds at its end until that result is taken.
// Config: APB, swap limit at 0x0, abort level at 0x4; write while idle.
module block_transposition_edit_distance (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] distance
  output logic [0:0]  m_tuser,   // [0] too_long
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import btedit_pkg::*;

  logic [BL_W-1:0] swap_limit;
  logic [MD_W-1:0] abort_level;
  logic            cfg_we;
  dp_cmd_t         cmd;
  dp_status_t      sts;
  logic            too_long;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // register index is paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_limit  <= BL_W'(2);
      abort_level <= MD_W'(255);
    end else if (cfg_we) begin
      if (paddr[2]) begin
        abort_level <= pwdata[MD_W-1:0];
      end else begin
        swap_limit <= pwdata[BL_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32-MD_W){1'b0}}, abort_level}
                           : {{(32-BL_W){1'b0}}, swap_limit};

  btedit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  btedit_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (s_tdata),
    .swap_limit   (swap_limit),
    .abort_level  (abort_level),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_distance (m_tdata),
    .out_too_long (too_long)
  );

  assign m_tuser[0] = too_long;

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for block_transposition_edit_distance.
// Depends on btedit_pkg and the block itself.
// Streams string bytes and finish words, predicts each distance, checks it.
module testbench;
  import btedit_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_BLOCK_LIMIT = 3'h0;
  localparam logic [2:0] ADDR_MAX_DISTANCE = 3'h4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] distance;
    logic       too_long;
  } out_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  block_transposition_edit_distance dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Bench copy of the block's state and registers.
  logic [7:0] str_a [0:MAX_LEN-1];
  logic [7:0] str_b [0:MAX_LEN-1];
  int         len_a, len_b;
  bit         dropped;
  int         blk_limit_q = 2;
  int         max_dist_q = 255;

  in_word_t   pending_words[$];
  out_word_t  expected_dist[$];
  int         send_idle, recv_idle;
  bit         send_hold;
  bit         in_fire;
  int         errors, results_seen, words_queued, finishes_queued;

  // Clock and reset
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int min3(int x, int y, int z);
    int r;
    r = x < y ? x : y;
    return r < z ? r : z;
  endfunction

  // Do the two adjacent blocks of length len ending at (s,t) appear swapped?
  function automatic bit blocks_swapped(int off, int s, int t, int len);
    if (s < 2 * len || t < 2 * len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (str_a[off + s - 2*len + k] != str_b[off + t - len + k]) return 1'b0;
      if (str_a[off + s - len + k] != str_b[off + t - 2*len + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int edit_distance();
    int  cost [0:MAX_LEN][0:MAX_LEN];
    int  p, e1, e2, n1, n2, base, best, sub, v;
    bit  same;
    same = (len_a == len_b);
    for (int k = 0; k < len_a && same; k++) if (str_a[k] != str_b[k]) same = 1'b0;
    if (same) return 0;
    if (len_a == 0 || len_b == 0) return len_a > len_b ? len_a : len_b;
    if (len_a == 1 && len_b == 1) return 1;
    // trim common prefix, then common suffix
    p = 0;
    while (p < len_a && p < len_b && str_a[p] == str_b[p]) p++;
    e1 = len_a - 1;
    e2 = len_b - 1;
    while (e1 >= p && e2 >= p && str_a[e1] == str_b[e2]) begin
      e1--;
      e2--;
    end
    n1 = e1 - p + 1;
    n2 = e2 - p + 1;
    if (n1 <= 0 || n2 <= 0) begin
      if (n1 < 0) n1 = 0;
      if (n2 < 0) n2 = 0;
      return n1 > n2 ? n1 : n2;
    end
    if (n1 == 1 && n2 == 1) return 1;
    for (int t = 0; t <= n2; t++) cost[0][t] = t;
    for (int s = 0; s <= n1; s++) cost[s][0] = s;
    base = (n1 / 2 < n2 / 2) ? n1 / 2 : n2 / 2;
    if (blk_limit_q < base) base = blk_limit_q;
    best = max_dist_q;   // running minimum, seeded with the threshold
    for (int s = 1; s <= n1; s++) begin
      for (int t = 1; t <= n2; t++) begin
        sub = (str_a[p + s - 1] == str_b[p + t - 1]) ? 0 : 1;
        v = -1;
        // longest matching block swap wins
        for (int len = base; len >= 1; len--) begin
          if (blocks_swapped(p, s, t, len)) begin
            v = min3(cost[s][t-1] + 1, cost[s-1][t] + 1,
                     cost[s - 2*len][t - 2*len] + sub + len - 1);
            break;
          end
        end
        if (v < 0) v = min3(cost[s][t-1] + 1, cost[s-1][t] + 1, cost[s-1][t-1] + sub);
        cost[s][t] = v;
        if (best > v) best = v;
      end
      if (best >= max_dist_q) return best;   // early abort after each row
    end
    return cost[n1][n2];
  endfunction

  // Update the bench state for one accepted word; a finish queues a result.
  task automatic take_word(in_word_t w);
    int d;
    out_word_t r;
    case (w.command)
      CMD_APPEND_A: begin
        if (len_a < MAX_LEN) begin
          str_a[len_a] = w.data_byte;
          len_a++;
        end else dropped = 1'b1;
      end
      CMD_APPEND_B: begin
        if (len_b < MAX_LEN) begin
          str_b[len_b] = w.data_byte;
          len_b++;
        end else dropped = 1'b1;
      end
      CMD_FINISH: begin
        d = edit_distance();
        if (d > 255) d = 255;
        r.distance = d[7:0];
        r.too_long = dropped;
        expected_dist.push_back(r);
        len_a = 0;
        len_b = 0;
        dropped = 1'b0;
      end
      default: ;   // unused command: no effect
    endcase
  endtask

  // Input monitor and result checker, both at the rising edge
  always @(posedge clk) begin
    out_word_t exp_w;
    in_fire = !rst && s_tvalid && s_tready;
    if (in_fire) take_word('{command: s_tuser, data_byte: s_tdata});
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_dist.size() == 0) begin
        $error("unexpected result word: distance %0d too_long %0d", m_tdata, m_tuser);
        errors++;
      end else begin
        exp_w = expected_dist.pop_front();
        if (m_tdata !== exp_w.distance) begin
          $error("distance: expected %0d, actual %0d", exp_w.distance, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== exp_w.too_long) begin
          $error("too_long: expected %0d, actual %0d", exp_w.too_long, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Driver: new word or idle at the falling edge, only when the slot is free
  always @(negedge clk) begin
    in_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (!s_tvalid || in_fire) begin
        if (pending_words.size() != 0 && !send_hold &&
            $urandom_range(0, 99) >= send_idle) begin
          w = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= w.command;
          s_tdata  <= w.data_byte;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic push_word(logic [1:0] cmd, logic [7:0] b);
    pending_words.push_back('{command: cmd, data_byte: b});
    if (cmd != CMD_UNUSED) words_queued++;
    if (cmd == CMD_FINISH) finishes_queued++;
  endtask

  // Queue one string pair and a finish. The second string is the first with
  // random edits, block swaps most often, so the matrix path sees real work.
  task automatic queue_pair(int la, int alpha, int edits, bit noisy);
    logic [7:0] a[$], b[$], tmp[$];
    int pos, bl, op;
    for (int k = 0; k < la; k++)
      a.push_back(alpha >= 256 ? 8'($urandom) : 8'($urandom_range(0, alpha - 1)));
    b = a;
    for (int e = 0; e < edits; e++) begin
      op = $urandom_range(0, 4);
      if (op <= 1 && b.size() >= 2) begin
        bl = $urandom_range(1, b.size() / 2);
        pos = $urandom_range(0, b.size() - 2 * bl);
        tmp = b[pos : pos + bl - 1];
        for (int k = 0; k < bl; k++) b[pos + k] = b[pos + bl + k];
        for (int k = 0; k < bl; k++) b[pos + bl + k] = tmp[k];
      end else if (op == 2 && b.size() != 0) begin
        b[$urandom_range(0, b.size() - 1)] = 8'($urandom);
      end else if (op == 3 && b.size() != 0) begin
        b.delete($urandom_range(0, b.size() - 1));
      end else begin
        b.insert($urandom_range(0, b.size()), 8'($urandom_range(0, alpha - 1)));
      end
    end
    foreach (a[k]) push_word(CMD_APPEND_A, a[k]);
    foreach (b[k]) begin
      if (noisy && $urandom_range(0, 9) == 0) push_word(CMD_UNUSED, 8'($urandom));
      push_word(CMD_APPEND_B, b[k]);
    end
    push_word(CMD_FINISH, 8'($urandom));
  endtask

  // APB write, setup then access
  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_BLOCK_LIMIT) blk_limit_q = value & 32'h3F;
    else max_dist_q = value & 32'hFF;
  endtask

  // Wait until all words are in and all results are out, then let it settle.
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || expected_dist.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(int bl, int md);
    drain();
    reg_write(ADDR_BLOCK_LIMIT, bl);
    reg_write(ADDR_MAX_DISTANCE, md);
  endtask

  // Random traffic: mostly related short strings, some noise and unrelated pairs.
  task automatic random_run(int target, int max_len);
    while (words_queued < target) begin
      case ($urandom_range(0, 9))
        0: queue_pair($urandom_range(0, max_len), 256, 0, 1'b1);
        1: begin
          repeat ($urandom_range(0, max_len)) push_word(CMD_APPEND_A, 8'($urandom));
          repeat ($urandom_range(0, max_len)) push_word(CMD_APPEND_B, 8'($urandom));
          push_word(CMD_FINISH, 8'($urandom));
        end
        default: queue_pair($urandom_range(1, max_len), $urandom_range(2, 6),
                            $urandom_range(0, 3), 1'b1);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    len_a = 0; len_b = 0; dropped = 1'b0;
    send_idle = 22; recv_idle = 79; send_hold = 1'b0;
    errors = 0; results_seen = 0; words_queued = 0; finishes_queued = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset register values: empty, equal, one byte each, a trimmed
    // remainder empty on one side, a pure 2-byte block swap, unused command.
    push_word(CMD_FINISH, 8'hFF);
    push_word(CMD_APPEND_A, 8'h00);
    push_word(CMD_APPEND_B, 8'h00);
    push_word(CMD_FINISH, 8'h00);
    push_word(CMD_APPEND_A, 8'hFF);
    push_word(CMD_APPEND_B, 8'h55);
    push_word(CMD_UNUSED, 8'hAA);
    push_word(CMD_FINISH, 8'h00);
    push_word(CMD_APPEND_A, 8'h61); push_word(CMD_APPEND_A, 8'h62);
    push_word(CMD_APPEND_A, 8'h63);
    push_word(CMD_APPEND_B, 8'h61); push_word(CMD_APPEND_B, 8'h63);
    push_word(CMD_FINISH, 8'h00);   // trimmed remainder empty on one side
    push_word(CMD_APPEND_A, 8'h01); push_word(CMD_APPEND_A, 8'h02);
    push_word(CMD_APPEND_A, 8'h03); push_word(CMD_APPEND_A, 8'h04);
    push_word(CMD_APPEND_B, 8'h03); push_word(CMD_APPEND_B, 8'h04);
    push_word(CMD_APPEND_B, 8'h01); push_word(CMD_APPEND_B, 8'h02);
    push_word(CMD_FINISH, 8'h00);
    // string overflow: 66 bytes into the first string
    for (int k = 0; k < MAX_LEN + 2; k++) push_word(CMD_APPEND_A, 8'(k * 37));
    push_word(CMD_APPEND_B, 8'h25);
    push_word(CMD_FINISH, 8'h00);

    // Both registers at their low end: no block swaps, instant abort
    set_regs(0, 0);
    random_run(250, 8);

    // Block length above any half-length in this run, abort threshold out of reach
    set_regs(32, 255);
    random_run(450, 12);
    repeat (2000) @(posedge clk);
    send_hold = 1'b1;   // sender pauses until the block is empty
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    send_hold = 1'b0;

    send_idle = 79; recv_idle = 22;
    set_regs($urandom_range(1, 6), $urandom_range(1, 4));   // early abort likely
    random_run(700, 10);
    set_regs(2, $urandom_range(5, 254));
    repeat (2) queue_pair(MAX_LEN, 4, 3, 1'b0);   // full-length strings
    queue_pair(MAX_LEN + 3, 256, 1, 1'b0);
    random_run(900, 12);

    send_idle = 0; recv_idle = 0;
    set_regs($urandom_range(0, 32), $urandom_range(0, 255));
    random_run(1150, 12);

    drain();
    $display("covered %0d words and %0d finishes across six register settings,",
             words_queued, finishes_queued);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #80000000;
    $display("testbench failed");
    $finish;
  end

endmodule
